[design/stk_pkg.sv]
// Shared types and field widths for the bounded LIFO stack.
// No dependencies; compiled first.
package stk_pkg;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 10;
   localparam int STATUS_W = 2;
   localparam int LEVEL_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 3'd0,
      CMD_POP     = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_PEEP    = 3'd3,
      CMD_CHANGE  = 3'd4,
      CMD_DISPLAY = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_INVALID  = 2'd3
   } status_type;

endpackage

[design/stk_chan_if.sv]
// Valid/ready channel interfaces for the stack's request and response beats.
// Depends on stk_pkg for field widths.
interface stk_req_if;
   logic                              valid;
   logic                              ready;
   logic        [stk_pkg::CMD_W-1:0]   command;
   logic signed [stk_pkg::VALUE_W-1:0] value;
   logic        [stk_pkg::POS_W-1:0]   position;

   modport source (output valid, command, value, position, input ready);
   modport sink   (input valid, command, value, position, output ready);
endinterface

interface stk_rsp_if;
   logic                               valid;
   logic                               ready;
   logic        [stk_pkg::STATUS_W-1:0] status;
   logic signed [stk_pkg::VALUE_W-1:0]  data;
   logic        [stk_pkg::LEVEL_W-1:0]  level;
   logic                               last;

   modport source (output valid, status, data, level, last, input ready);
   modport sink   (input valid, status, data, level, last, output ready);
endinterface

[design/array_stack_with_peep_change.sv]
// Bounded LIFO stack with positional read (peep) and overwrite (change).
// Depends on stk_pkg, stk_chan_if, stk_mem and stk_ctrl.
//
//   channel   dir   fields                          beats per request
//   req_if    in    command, value, position        1
//   rsp_if    out   status, data, level, last       1, or level for display
//
// Push, change and every error respond in the cycle after acceptance.
// Pop, peek and peep read on acceptance, then load the read data; display
// reads, then loads, each entry from the top. Reset clears the state, fill
// count and response valid; entries are written before being read.
// A stalled response holds the sequencer; no new request is taken mid-walk.
module array_stack_with_peep_change #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   stk_req_if.sink    req_if,
   stk_rsp_if.source  rsp_if
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                               mem_wr_en;
   logic        [AW-1:0]               mem_wr_addr;
   logic signed [stk_pkg::VALUE_W-1:0] mem_wr_data;
   logic                               mem_rd_en;
   logic        [AW-1:0]               mem_rd_addr;
   logic signed [stk_pkg::VALUE_W-1:0] mem_rd_data;

   stk_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_ready    (req_if.ready),
      .req_command  (req_if.command),
      .req_value    (req_if.value),
      .req_position (req_if.position),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_status   (rsp_if.status),
      .rsp_data     (rsp_if.data),
      .rsp_level    (rsp_if.level),
      .rsp_last     (rsp_if.last),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   stk_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

[design/stk_mem.sv]
// Entry storage: one write port, one read port, registered read data.
// Depends on stk_pkg for the word width.
module stk_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic        [AW-1:0]               wr_addr,
   input  logic signed [stk_pkg::VALUE_W-1:0] wr_data,
   input  logic                               rd_en,
   input  logic        [AW-1:0]               rd_addr,
   output logic signed [stk_pkg::VALUE_W-1:0] rd_data
);

   logic signed [stk_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [stk_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/stk_ctrl.sv]
// Command sequencer: fill count, address generation, display walk and
// the response register. Depends on stk_pkg; drives stk_mem.
module stk_ctrl #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic        [stk_pkg::CMD_W-1:0]     req_command,
   input  logic signed [stk_pkg::VALUE_W-1:0]   req_value,
   input  logic        [stk_pkg::POS_W-1:0]     req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic        [stk_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed [stk_pkg::VALUE_W-1:0]   rsp_data,
   output logic        [stk_pkg::LEVEL_W-1:0]   rsp_level,
   output logic                                 rsp_last,
   output logic                                 mem_wr_en,
   output logic        [AW-1:0]                 mem_wr_addr,
   output logic signed [stk_pkg::VALUE_W-1:0]   mem_wr_data,
   output logic                                 mem_rd_en,
   output logic        [AW-1:0]                 mem_rd_addr,
   input  logic signed [stk_pkg::VALUE_W-1:0]   mem_rd_data
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int PW = stk_pkg::POS_W;
   localparam int LW = stk_pkg::LEVEL_W;
   localparam int VW = stk_pkg::VALUE_W;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ISSUE = 3'b010,
      S_READ  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [FW-1:0]          fill_ff, fill_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic                   last_ff, last_in;
   logic                   out_valid_ff, out_valid_in;
   stk_pkg::status_type    out_status_ff, out_status_in;
   logic signed [VW-1:0]   out_data_ff, out_data_in;
   logic [LW-1:0]          out_level_ff, out_level_in;
   logic                   out_last_ff, out_last_in;

   logic                   out_free;
   logic                   accept;
   logic                   is_empty;
   logic                   is_full;
   logic                   pos_ok;
   logic [PW-1:0]          fill_ext;
   logic [AW-1:0]          top_addr;
   logic [AW-1:0]          pos_addr;
   stk_pkg::cmd_type       cmd;

   logic                   load;
   stk_pkg::status_type    ld_status;
   logic signed [VW-1:0]   ld_data;
   logic                   ld_last;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign cmd       = stk_pkg::cmd_type'(req_command);

   assign is_empty  = (fill_ff == '0);
   assign is_full   = (fill_ff == FW'(DEPTH));
   assign fill_ext  = PW'(fill_ff);
   assign pos_ok    = (req_position != '0) && (req_position <= fill_ext);
   assign top_addr  = AW'(fill_ff - FW'(1));
   // position 1 is the top entry, at address fill - 1
   assign pos_addr  = AW'(fill_ext - req_position);

   assign mem_wr_data = req_value;

   // A write and a read of the memory never fall in the same cycle, and a
   // read issued in the cycle after a write already sees the new word.
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_data_in   = out_data_ff;
      out_level_in  = out_level_ff;
      out_last_in   = out_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = AW'(fill_ff);
      mem_rd_en     = 1'b0;
      mem_rd_addr   = top_addr;
      load          = 1'b0;
      ld_status     = stk_pkg::ST_OK;
      ld_data       = '0;
      ld_last       = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  stk_pkg::CMD_PUSH: begin
                     load = 1'b1;
                     if (is_full) begin
                        ld_status = stk_pkg::ST_OVERFLOW;
                     end else begin
                        mem_wr_en = 1'b1;
                        fill_in   = fill_ff + FW'(1);
                     end
                  end
                  stk_pkg::CMD_POP, stk_pkg::CMD_PEEK: begin
                     if (is_empty) begin
                        load      = 1'b1;
                        ld_status = stk_pkg::ST_EMPTY;
                     end else begin
                        mem_rd_en = 1'b1;
                        last_in   = 1'b1;
                        state_in  = S_READ;
                        if (cmd == stk_pkg::CMD_POP) begin
                           fill_in = fill_ff - FW'(1);
                        end
                     end
                  end
                  stk_pkg::CMD_PEEP: begin
                     if (!pos_ok) begin
                        load      = 1'b1;
                        ld_status = stk_pkg::ST_INVALID;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = pos_addr;
                        last_in     = 1'b1;
                        state_in    = S_READ;
                     end
                  end
                  stk_pkg::CMD_CHANGE: begin
                     load = 1'b1;
                     if (!pos_ok) begin
                        ld_status = stk_pkg::ST_INVALID;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = pos_addr;
                     end
                  end
                  stk_pkg::CMD_DISPLAY: begin
                     if (is_empty) begin
                        load      = 1'b1;
                        ld_status = stk_pkg::ST_EMPTY;
                     end else begin
                        // walk from the top down to address zero
                        mem_rd_en = 1'b1;
                        addr_in   = top_addr;
                        last_in   = (top_addr == '0);
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     // unused command codes: beat consumed, no response
                  end
               endcase
            end
         end
         S_ISSUE: begin
            if (out_free) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = addr_ff;
               last_in     = (addr_ff == '0);
               state_in    = S_READ;
            end
         end
         S_READ: begin
            // response register is known free here: the read was issued
            // only when it was
            load    = 1'b1;
            ld_data = mem_rd_data;
            ld_last = last_ff;
            if (last_ff) begin
               state_in = S_IDLE;
            end else begin
               addr_in  = addr_ff - AW'(1);
               state_in = S_ISSUE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         out_valid_in  = 1'b1;
         out_status_in = ld_status;
         out_data_in   = ld_data;
         out_level_in  = LW'(fill_in);
         out_last_in   = ld_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      last_ff       <= last_in;
      out_status_ff <= out_status_in;
      out_data_ff   <= out_data_in;
      out_level_ff  <= out_level_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_data   = out_data_ff;
   assign rsp_level  = out_level_ff;
   assign rsp_last   = out_last_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the bounded LIFO stack: directed table, then random traffic.
// Depends on stk_pkg, the stk_req_if/stk_rsp_if channels and array_stack_with_peep_change.
module testbench;

   localparam int STACK_DEPTH = 16;
   localparam int HOLD_CYCLES = 80;
   localparam int TAIL_CYCLES = 40;
   localparam int IDLE_LIMIT  = 2000;

   // codes outside the command set; the stack must ignore them
   localparam logic [stk_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [stk_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [stk_pkg::CMD_W-1:0]   cmd;
      logic [stk_pkg::VALUE_W-1:0] value;
      logic [stk_pkg::POS_W-1:0]   pos;
   } stack_req_type;

   typedef struct packed {
      stk_pkg::status_type         status;
      logic [stk_pkg::VALUE_W-1:0] data;
      logic [stk_pkg::LEVEL_W-1:0] level;
      logic                        last;
   } stack_beat_type;

   typedef struct {
      logic [stk_pkg::CMD_W-1:0]   cmd;
      logic [stk_pkg::VALUE_W-1:0] value;
      logic [stk_pkg::POS_W-1:0]   pos;
      int                          reps;
      bit                          typed;
      stk_pkg::status_type         status;
      logic [stk_pkg::VALUE_W-1:0] data;
      logic [stk_pkg::LEVEL_W-1:0] level;
   } stim_row_type;

   logic clock;
   logic reset;

   stk_req_if req_ch ();
   stk_rsp_if rsp_ch ();

   array_stack_with_peep_change #(
      .DEPTH (STACK_DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // predictor state
   logic [stk_pkg::VALUE_W-1:0] stack_words [STACK_DEPTH];
   int unsigned                 stack_level;
   stack_beat_type              step_beats [$];
   stack_beat_type              rsp_expect [$];
   stack_beat_type              head_beat;
   stim_row_type                dir_table [$];

   int  mismatch_cnt;
   int  idle_cycles;
   bit  no_idle;
   bit  hold_rsp;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 200)
         $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   function automatic void add_beat(stk_pkg::status_type st,
                                    logic [stk_pkg::VALUE_W-1:0] data, logic last);
      step_beats.push_back('{st, data, stk_pkg::LEVEL_W'(stack_level), last});
   endfunction

   // Applies one request to the shadow stack; leaves the beats it causes in step_beats.
   function automatic void predict_stack_op(logic [stk_pkg::CMD_W-1:0] cmd,
                                            logic [stk_pkg::VALUE_W-1:0] val,
                                            logic [stk_pkg::POS_W-1:0] pos);
      int unsigned idx;
      step_beats.delete();
      unique case (cmd)
         stk_pkg::CMD_PUSH: begin
            if (stack_level >= STACK_DEPTH) begin
               add_beat(stk_pkg::ST_OVERFLOW, '0, 1'b1);
            end else begin
               stack_words[stack_level] = val;
               stack_level++;
               add_beat(stk_pkg::ST_OK, '0, 1'b1);
            end
         end
         stk_pkg::CMD_POP: begin
            if (stack_level == 0) begin
               add_beat(stk_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               stack_level--;
               add_beat(stk_pkg::ST_OK, stack_words[stack_level], 1'b1);
            end
         end
         stk_pkg::CMD_PEEK: begin
            if (stack_level == 0) add_beat(stk_pkg::ST_EMPTY, '0, 1'b1);
            else add_beat(stk_pkg::ST_OK, stack_words[stack_level-1], 1'b1);
         end
         stk_pkg::CMD_PEEP, stk_pkg::CMD_CHANGE: begin
            if (pos < 1 || pos > stack_level) begin
               add_beat(stk_pkg::ST_INVALID, '0, 1'b1);
            end else begin
               idx = stack_level - pos;
               if (cmd == stk_pkg::CMD_PEEP) begin
                  add_beat(stk_pkg::ST_OK, stack_words[idx], 1'b1);
               end else begin
                  stack_words[idx] = val;
                  add_beat(stk_pkg::ST_OK, '0, 1'b1);
               end
            end
         end
         stk_pkg::CMD_DISPLAY: begin
            if (stack_level == 0) begin
               add_beat(stk_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               for (int k = 0; k < stack_level; k++)
                  add_beat(stk_pkg::ST_OK, stack_words[stack_level-1-k],
                           (k + 1) == stack_level);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [stk_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 7) != 0) return $urandom;
      unique case ($urandom_range(0, 3))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   // Mostly in-range positions, with some off-by-one, zero and full-range ones.
   function automatic logic [stk_pkg::POS_W-1:0] pick_position();
      unique case ($urandom_range(0, 9))
         0: return stk_pkg::POS_W'($urandom_range(0, 1023));
         1: return '0;
         2: return stk_pkg::POS_W'(stack_level + 1);
         default: return (stack_level == 0) ? stk_pkg::POS_W'(1)
                                            : stk_pkg::POS_W'($urandom_range(1, stack_level));
      endcase
   endfunction

   function automatic stack_req_type pick_request(int push_w, int pop_w);
      stack_req_type rq;
      int            r;
      r = $urandom_range(0, 99);
      if (r < push_w) begin
         rq.cmd = stk_pkg::CMD_PUSH;
      end else if (r < push_w + pop_w) begin
         rq.cmd = stk_pkg::CMD_POP;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 15) rq.cmd = stk_pkg::CMD_PEEK;
         else if (r < 45) rq.cmd = stk_pkg::CMD_PEEP;
         else if (r < 75) rq.cmd = stk_pkg::CMD_CHANGE;
         else if (r < 92) rq.cmd = stk_pkg::CMD_DISPLAY;
         else rq.cmd = r[0] ? CMD_SPARE_7 : CMD_SPARE_6;
      end
      rq.value = pick_value();
      rq.pos   = pick_position();
      return rq;
   endfunction

   // Offers one beat after a random gap and returns at the edge that takes it.
   task automatic send_request(input stack_req_type rq);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.command  <= rq.cmd;
      req_ch.value    <= rq.value;
      req_ch.position <= rq.pos;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic apply_request(input stack_req_type rq, input bit typed,
                                input stack_beat_type typed_beat);
      send_request(rq);
      predict_stack_op(rq.cmd, rq.value, rq.pos);
      if (typed) rsp_expect.push_back(typed_beat);
      else foreach (step_beats[j]) rsp_expect.push_back(step_beats[j]);
   endtask

   task automatic run_random(int count, int push_w, int pop_w);
      stack_req_type rq;
      int            done;
      done = 0;
      while (done < count) begin
         rq = pick_request(push_w, pop_w);
         apply_request(rq, 1'b0, '0);
         if (rq.cmd <= stk_pkg::CMD_DISPLAY) done++;
      end
   endtask

   // returns at a later edge, so the next request never lands in the same step
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (rsp_expect.size() != 0);
   endtask

   // response side: random ready gaps, plus one long hold on request
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (hold_rsp) begin
            gap      = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rsp_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected beat status %0d data %h level %0d last %0d",
                                      rsp_ch.status, rsp_ch.data, rsp_ch.level, rsp_ch.last));
         end else begin
            head_beat = rsp_expect.pop_front();
            if (rsp_ch.status !== head_beat.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_ch.status, head_beat.status));
            if (rsp_ch.data !== head_beat.data)
               report_mismatch($sformatf("data %h, want %h", rsp_ch.data, head_beat.data));
            if (rsp_ch.level !== head_beat.level)
               report_mismatch($sformatf("level %0d, want %0d",
                                         rsp_ch.level, head_beat.level));
            if (rsp_ch.last !== head_beat.last)
               report_mismatch($sformatf("last %0d, want %0d", rsp_ch.last, head_beat.last));
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("array_stack_with_peep_change test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      stack_req_type  rq;
      stack_beat_type tb_beat;

      clock           = 1'b0;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.command  = '0;
      req_ch.value    = '0;
      req_ch.position = '0;
      mismatch_cnt    = 0;
      idle_cycles     = 0;
      no_idle         = 1'b0;
      hold_rsp        = 1'b0;
      stack_level     = 0;
      foreach (stack_words[i]) stack_words[i] = '0;

      // cmd, value, position, reps, typed, status, data, level
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_POP, 32'h0, 10'd0, 1,
                                         1'b1, stk_pkg::ST_EMPTY, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PEEK, 32'h0, 10'd0, 1,
                                         1'b1, stk_pkg::ST_EMPTY, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_DISPLAY, 32'h0, 10'd0, 1,
                                         1'b1, stk_pkg::ST_EMPTY, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PEEP, 32'h0, 10'd1, 1,
                                         1'b1, stk_pkg::ST_INVALID, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_CHANGE, 32'h1, 10'd0, 1,
                                         1'b1, stk_pkg::ST_INVALID, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{CMD_SPARE_6, 32'h1, 10'd1, 1,
                                         1'b0, stk_pkg::ST_OK, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{CMD_SPARE_7, 32'h1, 10'd1, 1,
                                         1'b0, stk_pkg::ST_OK, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PUSH, 32'h7fff_ffff, 10'd0, 1,
                                         1'b1, stk_pkg::ST_OK, 32'h0, 5'd1});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PUSH, 32'h8000_0000, 10'd0, 1,
                                         1'b1, stk_pkg::ST_OK, 32'h0, 5'd2});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PEEK, 32'h0, 10'd0, 1,
                                         1'b1, stk_pkg::ST_OK, 32'h8000_0000, 5'd2});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PEEP, 32'h0, 10'd2, 1,
                                         1'b1, stk_pkg::ST_OK, 32'h7fff_ffff, 5'd2});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PEEP, 32'h0, 10'd0, 1,
                                         1'b1, stk_pkg::ST_INVALID, 32'h0, 5'd2});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PEEP, 32'h0, 10'd3, 1,
                                         1'b1, stk_pkg::ST_INVALID, 32'h0, 5'd2});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_CHANGE, 32'hffff_ffff, 10'd1023, 1,
                                         1'b1, stk_pkg::ST_INVALID, 32'h0, 5'd2});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_CHANGE, 32'hffff_ffff, 10'd2, 1,
                                         1'b1, stk_pkg::ST_OK, 32'h0, 5'd2});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_DISPLAY, 32'h0, 10'd0, 1,
                                         1'b0, stk_pkg::ST_OK, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PUSH, 32'h5a5a_5a5a, 10'd0, 14,
                                         1'b0, stk_pkg::ST_OK, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PUSH, 32'h1, 10'd0, 1,
                                         1'b1, stk_pkg::ST_OVERFLOW, 32'h0, 5'd16});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PEEP, 32'h0, 10'd16, 1,
                                         1'b1, stk_pkg::ST_OK, 32'hffff_ffff, 5'd16});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_PEEP, 32'h0, 10'd17, 1,
                                         1'b1, stk_pkg::ST_INVALID, 32'h0, 5'd16});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_CHANGE, 32'h0, 10'd16, 1,
                                         1'b1, stk_pkg::ST_OK, 32'h0, 5'd16});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_DISPLAY, 32'h0, 10'd0, 1,
                                         1'b0, stk_pkg::ST_OK, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_POP, 32'h0, 10'd0, 1,
                                         1'b1, stk_pkg::ST_OK, 32'h5a5a_5a5a, 5'd15});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_POP, 32'h0, 10'd0, 15,
                                         1'b0, stk_pkg::ST_OK, 32'h0, 5'd0});
      dir_table.push_back(stim_row_type'{stk_pkg::CMD_POP, 32'h0, 10'd0, 1,
                                         1'b1, stk_pkg::ST_EMPTY, 32'h0, 5'd0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         for (int n = 0; n < dir_table[i].reps; n++) begin
            rq      = '{dir_table[i].cmd, dir_table[i].value, dir_table[i].pos};
            tb_beat = '{dir_table[i].status, dir_table[i].data, dir_table[i].level, 1'b1};
            apply_request(rq, dir_table[i].typed, tb_beat);
         end
      end

      run_random(100, 45, 20);   // fill up
      no_idle = 1'b1;
      run_random(50, 35, 35);    // back-to-back on both sides
      no_idle  = 1'b0;
      hold_rsp = 1'b1;           // receiver stalls while pushes keep coming
      run_random(30, 60, 10);
      drain_responses();
      run_random(100, 25, 45);   // drain down
      run_random(80, 40, 30);

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && rsp_expect.size() == 0) begin
         $display("array_stack_with_peep_change test passed");
      end else begin
         $display("array_stack_with_peep_change test failed");
      end
      $finish;
   end

endmodule
